// ===== design/lpsd_pkg.sv =====
// shared types and constants for the length-prefixed section deframer
`default_nettype none

package lpsd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int CAP_W  = 20;
  localparam int ERR_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 20'd65536;

  localparam logic [1:0] PH_LEN_HI = 2'd0;
  localparam logic [1:0] PH_LEN_LO = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LEN_BIG  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CAPACITY = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_data;
    logic              parcel_end;
    logic [ERR_W-1:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== design/lpsd_parser.sv =====
// header/payload parser: framing state and per-beat result decode
`default_nettype none

module lpsd_parser #(
  parameter int MAX_SECTION = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lpsd_pkg::CAP_W-1:0]  cfg_wr_data,
  input  wire logic                        beat_fire,
  input  wire logic [lpsd_pkg::BYTE_W-1:0] beat_byte,
  output logic                             res_valid,
  output lpsd_pkg::result_t                res
);
  import lpsd_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SECTION);

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              full_r, full_nxt;
  logic [CAP_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;

  logic [LEN_W-1:0]  len;
  logic [CAP_W:0]    sum;
  logic              len_big;
  logic              len_zero;
  logic              over_cap;
  logic [LEN_W-1:0]  left_dec;

  assign len      = {len_hi_r, beat_byte};
  assign sum      = {1'b0, count_r} + {{(CAP_W+1-LEN_W){1'b0}}, len};
  assign len_big  = len > MAX_LEN;
  assign len_zero = len == '0;
  assign over_cap = sum > {1'b0, cap_r};
  assign left_dec = left_r - LEN_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    full_nxt   = full_r;
    count_nxt  = count_r;
    res_valid  = 1'b0;
    res        = '{out_byte: '0, has_data: 1'b0, parcel_end: 1'b0, error_code: ERR_NONE};
    case (phase_r)
      PH_LEN_LO: begin
        phase_nxt = PH_LEN_HI;
        if (len_big) begin
          count_nxt      = '0;
          res_valid      = 1'b1;
          res.error_code = ERR_LEN_BIG;
        end else if (len_zero) begin
          count_nxt      = '0;
          res_valid      = 1'b1;
          res.parcel_end = 1'b1;
        end else if (over_cap) begin
          count_nxt      = '0;
          res_valid      = 1'b1;
          res.error_code = ERR_CAPACITY;
        end else begin
          left_nxt  = len;
          full_nxt  = len == MAX_LEN;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        left_nxt     = left_dec;
        count_nxt    = count_r + CAP_W'(1);
        res_valid    = 1'b1;
        res.out_byte = beat_byte;
        res.has_data = 1'b1;
        if (left_dec == '0) begin
          phase_nxt      = PH_LEN_HI;
          res.parcel_end = !full_r;
          if (!full_r) begin
            count_nxt = '0;
          end
        end
      end
      default: begin
        len_hi_nxt = beat_byte;
        phase_nxt  = PH_LEN_LO;
      end
    endcase
    if (!beat_fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN_HI;
      len_hi_r <= '0;
      left_r   <= '0;
      full_r   <= 1'b0;
      count_r  <= '0;
      cap_r    <= CAP_RESET;
    end else begin
      if (beat_fire) begin
        phase_r  <= phase_nxt;
        len_hi_r <= len_hi_nxt;
        left_r   <= left_nxt;
        full_r   <= full_nxt;
        count_r  <= count_nxt;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload phase always has bytes still due, never more than a full section
  a_left_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> (left_r != '0 && left_r <= MAX_LEN))
    else $error("payload phase with bad remaining count");

  // full-section flag only set by a maximum-length header
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r == PH_DATA) |-> (full_r == (left_r == MAX_LEN)))
    else $error("full-section flag disagrees with length");

  // only the three framing phases are ever reached
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LEN_HI || phase_r == PH_LEN_LO || phase_r == PH_DATA)
    else $error("unused framing phase");

endmodule

`default_nettype wire

// ===== design/lpsd_out_buf.sv =====
// result register with skid stage
`default_nettype none

module lpsd_out_buf (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire lpsd_pkg::result_t push_res,
  output logic              can_push,
  output logic              out_valid,
  input  wire logic         out_ready,
  output lpsd_pkg::result_t out_res
);
  import lpsd_pkg::*;

  logic    main_v_r;
  logic    skid_v_r;
  result_t main_r;
  result_t skid_r;

  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      main_r <= skid_v_r ? skid_r : push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  // skid only holds a beat behind a held result
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid full with empty result register");

  // skid fills only from a push against a stalled result
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(main_v_r && !out_ready && push))
    else $error("skid filled without a stall");

  // a push never lands while the skid is occupied
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("beat pushed into full buffer");

endmodule

`default_nettype wire

// ===== design/length_prefixed_section_deframer.sv =====
// top level of the length-prefixed section deframer
//
//  port group  dir  width        handshake
//  in_*        in   8            in_valid / in_ready
//  out_*       out  8+1+1+2      out_valid / out_ready
//  cfg_*       in   20           cfg_wr_en, no wait
//
// one beat per cycle sustained while the output is not stalled; each result
// is registered in the output register, or in the skid stage behind a stall
// header and payload decode sit between the input beat and the result register
// in_ready drops only while the skid stage holds a beat behind a stalled output
// rst_n is synchronous; capacity returns to 65536, framing to the length high byte
`default_nettype none

module length_prefixed_section_deframer #(
  parameter int MAX_SECTION = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lpsd_pkg::BYTE_W-1:0] in_data_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lpsd_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_has_data,
  output logic                             out_parcel_end,
  output logic [lpsd_pkg::ERR_W-1:0]       out_error_code,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lpsd_pkg::CAP_W-1:0]  cfg_wr_data
);
  import lpsd_pkg::*;

  logic    beat_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign beat_fire = in_valid && in_ready;

  lpsd_parser #(
    .MAX_SECTION(MAX_SECTION)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .beat_fire  (beat_fire),
    .beat_byte  (in_data_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  lpsd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_res (res),
    .can_push (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_byte       = out_res.out_byte;
  assign out_has_data   = out_res.has_data;
  assign out_parcel_end = out_res.parcel_end;
  assign out_error_code = out_res.error_code;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the length-prefixed section deframer
`default_nettype none

module tb_top;
  import lpsd_pkg::*;

  localparam int MAX_SECTION  = 1024;
  localparam int SETTLE       = 8;
  localparam int PHASE_BEATS  = 45;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [1:0]       phase;
    logic [7:0]       len_hi;
    logic [LEN_W-1:0] left;
    logic             full_sec;
    logic [CAP_W-1:0] count;
    logic [CAP_W-1:0] cap;
  } deframer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_has_data;
  logic                out_parcel_end;
  logic [ERR_W-1:0]    out_error_code;
  logic                cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]    cfg_wr_data = '0;

  logic [BYTE_W-1:0]   pending_bytes[$];
  result_t             expected_results[$];
  deframer_t           pred_st;
  deframer_t           gen_st;
  result_t             predicted;
  result_t             gen_scratch;
  result_t             want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned parcel_ends = 0;
  int unsigned len_errors = 0;
  int unsigned cap_errors = 0;
  int unsigned bytes_queued = 0;
  int unsigned cycles = 0;

  length_prefixed_section_deframer #(
    .MAX_SECTION(MAX_SECTION)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_has_data   (out_has_data),
    .out_parcel_end (out_parcel_end),
    .out_error_code (out_error_code),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one stream byte through the framing state; returns 1 when a result beat is due
  function automatic bit deframe_byte(inout deframer_t st, input logic [7:0] b,
                                      output result_t r);
    int unsigned len;
    bit produced;
    produced = 1'b0;
    r = '0;
    r.error_code = ERR_NONE;
    case (st.phase)
      PH_LEN_LO: begin
        len = 32'({st.len_hi, b});
        st.phase = PH_LEN_HI;
        if (len > MAX_SECTION) begin
          st.count = '0;
          r.error_code = ERR_LEN_BIG;
          produced = 1'b1;
        end else if (len == 0) begin
          st.count = '0;
          r.parcel_end = 1'b1;
          produced = 1'b1;
        end else if (st.count + len > st.cap) begin
          st.count = '0;
          r.error_code = ERR_CAPACITY;
          produced = 1'b1;
        end else begin
          st.left = len[LEN_W-1:0];
          st.full_sec = (len == MAX_SECTION);
          st.phase = PH_DATA;
        end
      end
      PH_DATA: begin
        st.left = st.left - 1'b1;
        st.count = st.count + 1'b1;
        r.out_byte = b;
        r.has_data = 1'b1;
        produced = 1'b1;
        if (st.left == 0) begin
          st.phase = PH_LEN_HI;
          if (!st.full_sec) begin
            st.count = '0;
            r.parcel_end = 1'b1;
          end
        end
      end
      default: begin
        st.len_hi = b;
        st.phase = PH_LEN_LO;
      end
    endcase
    return produced;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    void'(deframe_byte(gen_st, b, gen_scratch));
    bytes_queued++;
  endtask

  // header, then payload for as long as the framing state takes it
  task automatic push_section(input int len);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    while (gen_st.phase == PH_DATA) push_byte($urandom_range(255));
  endtask

  task automatic random_parcel();
    int r;
    int len;
    int room;
    int n;
    r = $urandom_range(99);
    if (r < 64) begin
      n = $urandom_range(99);
      if (n < 12) len = 0;
      else if (n < 14) len = $urandom_range(MAX_SECTION - 1, 100);
      else len = $urandom_range(24, 1);
      push_section(len);
    end else if (r < 74) begin
      push_section($urandom_range(65535, MAX_SECTION + 1));
    end else if (r < 84) begin
      room = int'(gen_st.cap) - int'(gen_st.count);
      if (room >= 1 && room < MAX_SECTION) len = room + $urandom_range(1);
      else len = $urandom_range(30, 1);
      push_section(len);
    end else begin
      // junk bytes, then resync on a header boundary
      n = $urandom_range(6, 1);
      repeat (n) push_byte($urandom_range(255));
      while (gen_st.phase != PH_LEN_HI) push_byte($urandom_range(255));
    end
  endtask

  task automatic quiesce();
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pred_st.cap = c;
    gen_st.cap = c;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // input driver: beats come from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        beats_in++;
        if (deframe_byte(pred_st, in_data_byte, predicted))
          expected_results.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_left <= hold_len;
      hold_served <= hold_reqs;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: byte %0h data %0b end %0b err %0d",
                 out_byte, out_has_data, out_parcel_end, out_error_code);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte expected %0h actual %0h", want.out_byte, out_byte);
            mismatches++;
          end
          if (out_has_data !== want.has_data) begin
            $error("has_data expected %0b actual %0b", want.has_data, out_has_data);
            mismatches++;
          end
          if (out_parcel_end !== want.parcel_end) begin
            $error("parcel_end expected %0b actual %0b", want.parcel_end, out_parcel_end);
            mismatches++;
          end
          if (out_error_code !== want.error_code) begin
            $error("error_code expected %0d actual %0d", want.error_code, out_error_code);
            mismatches++;
          end
          if (want.parcel_end) parcel_ends++;
          if (want.error_code == ERR_LEN_BIG) len_errors++;
          if (want.error_code == ERR_CAPACITY) cap_errors++;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] caps[8];
    int unsigned start;
    caps = '{20'd1048575, 20'd1, 20'd37, 20'd700, 20'd1, 20'd65536, 20'd200, 20'd1048575};
    pred_st = '0;
    pred_st.phase = PH_LEN_HI;
    pred_st.cap = CAP_RESET;
    gen_st = pred_st;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty parcel, one-byte and two-byte parcels, oversize lengths
    push_section(0);
    push_byte(8'h00); push_byte(8'h01); push_byte(8'hFF);
    push_byte(8'h00); push_byte(8'h02); push_byte(8'h00); push_byte(8'hA5);
    push_byte(8'h04); push_byte(8'h01);
    push_byte(8'hFF); push_byte(8'hFF);
    quiesce();
    // tiny capacity: one over, then exactly full
    set_capacity(20'd3);
    push_byte(8'h00); push_byte(8'h04);
    push_byte(8'h00); push_byte(8'h03);
    push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
    quiesce();

    // full section carries the parcel on, short one closes it at exact capacity
    set_capacity(20'd1030);
    push_section(MAX_SECTION);
    push_section(6);
    quiesce();

    for (int i = 0; i < 8; i++) begin
      set_capacity(caps[i]);
      case (i % 4)
        0: set_idling(0, 0);
        1: set_idling(65, 0);
        2: set_idling(0, 65);
        default: set_idling(23, 23);
      endcase
      start = bytes_queued;
      while (bytes_queued - start < PHASE_BEATS) random_parcel();
      quiesce();
    end

    // output held off while input keeps coming
    set_capacity(CAP_RESET);
    set_idling(0, 0);
    hold_len = 300;
    @(posedge clk);
    hold_reqs <= hold_reqs + 1;
    start = bytes_queued;
    while (bytes_queued - start < 80) random_parcel();
    quiesce();

    $display("covered %0d input beats and %0d result beats: %0d parcel ends,",
             beats_in, beats_out, parcel_ends);
    $display("%0d length errors, %0d capacity errors; capacity from 1 to 1048575,",
             len_errors, cap_errors);
    $display("full-section continuation, idle/stall mixes, long output hold-off");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
